[rtl/rfmmm_pkg.sv]
// ----------------------------------------------------------------------------
// rfmmm_pkg - shared types and constants
// Sizes, status codes and sequencer states for the ring FIFO with stats.
// ----------------------------------------------------------------------------
package rfmmm_pkg;

  localparam int SLOTS   = 16;                 // ring slots, one kept unused
  localparam int IDX_W   = $clog2(SLOTS);      // slot index width
  localparam int DATA_W  = 32;                 // entry width
  localparam int CNT_W   = 4;                  // held entry count width
  localparam int SUM_W   = DATA_W + CNT_W;     // running sum, no overflow
  localparam int FRAC_W  = 8;                  // mean fraction bits
  localparam int DIVD_W  = SUM_W - 1 + FRAC_W; // dividend magnitude width
  localparam int MEAN_W  = 40;                 // mean result width
  localparam int STEP_W  = $clog2(DIVD_W + 1); // divider step counter width
  localparam int TDATA_W = ((DATA_W * 4 + CNT_W + MEAN_W - DATA_W + 7) / 8) * 8;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_WALK,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  // next slot round the ring
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(SLOTS - 1)) r = '0;
    else                        r = i + 1'b1;
    return r;
  endfunction

endpackage

[rtl/ring_fifo_with_min_max_mean_core.sv]
// ----------------------------------------------------------------------------
// ring_fifo_with_min_max_mean_core
// Ring FIFO of signed 32-bit values reporting count, max, min and Q.8 mean.
// ----------------------------------------------------------------------------
// Each input beat passes through update, load, a walk over the entries held after the request
// (up to 15), prep, the serial restoring divider and done, then the output register.
// One beat is handled at a time: the next is taken only once the result has been
// loaded into the output register. The entry walk, one store read at a time, and
// the serial divider set the pace.
// Reset (rst_n low, synchronous): head and tail to the last slot (empty), sequencer idle,
// no result pending. Store contents are not cleared.
module ring_fifo_with_min_max_mean_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rfmmm_pkg::DATA_W-1:0]     in_tdata,  // [31:0] push_value
  input  logic [0:0]                       in_tuser,  // [0] req_type
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] popped_value, [35:32] entry_count, [67:36] largest_entry,
  // [99:68] smallest_entry, [139:100] mean_q8, [143:140] zero
  output logic [rfmmm_pkg::TDATA_W-1:0]    out_tdata,
  output logic [1:0]                       out_tuser  // [1:0] status
);

  localparam int DW = rfmmm_pkg::DATA_W;
  localparam int IW = rfmmm_pkg::IDX_W;
  localparam int CW = rfmmm_pkg::CNT_W;
  localparam int SW = rfmmm_pkg::SUM_W;
  localparam int QW = rfmmm_pkg::DIVD_W;
  localparam int MW = rfmmm_pkg::MEAN_W;
  localparam int PAD_W = rfmmm_pkg::TDATA_W - (3 * DW + CW + MW);

  rfmmm_pkg::state_t state_r, state_nxt;

  // slot store, single write port, registered read
  logic [DW-1:0] mem [rfmmm_pkg::SLOTS];
  logic [DW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;

  logic [IW-1:0] head_r, tail_r;
  logic          req_r;
  logic [DW-1:0] value_r;
  rfmmm_pkg::status_t status_r;
  logic [DW-1:0] popped_r;
  logic [CW-1:0] count_r;

  // walk
  logic [IW-1:0] walk_idx_r;
  logic [CW-1:0] iss_r;
  logic          pend_r;
  logic signed [DW-1:0] max_r, min_r;
  logic signed [SW-1:0] sum_r;

  // divider
  logic [QW-1:0] quo_r;
  logic [CW-1:0] rem_r;
  logic [rfmmm_pkg::STEP_W-1:0] step_r;
  logic          neg_r;
  logic [CW:0]   trial;
  logic          trial_ge;

  // output register
  logic          out_valid_r;
  logic [rfmmm_pkg::TDATA_W-1:0] out_data_r;
  rfmmm_pkg::status_t out_stat_r;

  logic          in_fire, out_load, walk_issue, walk_end, div_end;
  logic          full_now, empty_now;
  logic [IW:0]   held;
  logic signed [DW-1:0] rd_s;
  logic [SW-1:0] sum_mag;
  logic [MW-1:0] mean_val;

  assign in_fire   = in_tvalid && in_tready;
  assign full_now  = rfmmm_pkg::next_slot(tail_r) == head_r;
  assign empty_now = tail_r == head_r;
  assign held      = (tail_r >= head_r) ? {1'b0, tail_r} - {1'b0, head_r}
                                        : {1'b0, tail_r} + (IW+1)'(rfmmm_pkg::SLOTS)
                                          - {1'b0, head_r};
  assign walk_issue = iss_r != count_r;
  assign walk_end   = !walk_issue && !pend_r;
  assign div_end    = step_r == rfmmm_pkg::STEP_W'(QW);
  assign rd_s       = rd_data_r;
  assign sum_mag    = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign trial      = {rem_r, quo_r[QW-1]};
  assign trial_ge   = trial >= {1'b0, count_r};
  assign mean_val   = neg_r ? MW'(-quo_r[MW-1:0]) : quo_r[MW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfmmm_pkg::ST_IDLE:   if (in_fire) state_nxt = rfmmm_pkg::ST_UPDATE;
      rfmmm_pkg::ST_UPDATE: state_nxt = rfmmm_pkg::ST_LOAD;
      rfmmm_pkg::ST_LOAD:   state_nxt = rfmmm_pkg::ST_WALK;
      rfmmm_pkg::ST_WALK:   if (walk_end) state_nxt = rfmmm_pkg::ST_PREP;
      rfmmm_pkg::ST_PREP:   state_nxt = rfmmm_pkg::ST_DIV;
      rfmmm_pkg::ST_DIV:    if (div_end) state_nxt = rfmmm_pkg::ST_DONE;
      rfmmm_pkg::ST_DONE:   if (out_load) state_nxt = rfmmm_pkg::ST_IDLE;
      default:              state_nxt = rfmmm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = walk_idx_r;
    out_load  = 1'b0;
    unique case (state_r)
      rfmmm_pkg::ST_IDLE:   in_tready = 1'b1;
      rfmmm_pkg::ST_UPDATE: begin
        wr_en   = (req_r == rfmmm_pkg::REQ_PUSH) && !full_now;
        rd_addr = rfmmm_pkg::next_slot(head_r);
      end
      rfmmm_pkg::ST_DONE:   out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // store
  always_ff @(posedge clk) begin
    if (wr_en) mem[rfmmm_pkg::next_slot(tail_r)] <= value_r;
    rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfmmm_pkg::ST_IDLE;
      head_r      <= IW'(rfmmm_pkg::SLOTS - 1);
      tail_r      <= IW'(rfmmm_pkg::SLOTS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rfmmm_pkg::ST_UPDATE) begin
        if (req_r == rfmmm_pkg::REQ_PUSH) begin
          if (!full_now) tail_r <= rfmmm_pkg::next_slot(tail_r);
        end else if (!empty_now) begin
          head_r <= rfmmm_pkg::next_slot(head_r);
        end
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_tuser[0];
      value_r <= in_tdata;
    end
    unique case (state_r)
      rfmmm_pkg::ST_UPDATE: begin
        popped_r <= '1;
        if (req_r == rfmmm_pkg::REQ_PUSH)
          status_r <= full_now ? rfmmm_pkg::STAT_FULL : rfmmm_pkg::STAT_DONE;
        else
          status_r <= empty_now ? rfmmm_pkg::STAT_EMPTY : rfmmm_pkg::STAT_DONE;
      end
      rfmmm_pkg::ST_LOAD: begin
        // pop read issued last cycle lands now
        if (req_r == rfmmm_pkg::REQ_POP && status_r == rfmmm_pkg::STAT_DONE)
          popped_r <= rd_data_r;
        count_r    <= held[CW-1:0];
        walk_idx_r <= rfmmm_pkg::next_slot(head_r);
        iss_r      <= '0;
        pend_r     <= 1'b0;
        max_r      <= {1'b1, {(DW-1){1'b0}}};
        min_r      <= {1'b0, {(DW-1){1'b1}}};
        sum_r      <= '0;
      end
      rfmmm_pkg::ST_WALK: begin
        pend_r <= walk_issue;
        if (walk_issue) begin
          iss_r      <= iss_r + 1'b1;
          walk_idx_r <= rfmmm_pkg::next_slot(walk_idx_r);
        end
        if (pend_r) begin
          sum_r <= sum_r + SW'(rd_s);
          if (rd_s > max_r) max_r <= rd_s;
          if (rd_s < min_r) min_r <= rd_s;
        end
      end
      rfmmm_pkg::ST_PREP: begin
        neg_r  <= sum_r[SW-1];
        quo_r  <= {sum_mag[SW-2:0], {rfmmm_pkg::FRAC_W{1'b0}}};
        rem_r  <= '0;
        step_r <= '0;
      end
      rfmmm_pkg::ST_DIV: begin
        // restoring division, one quotient bit a cycle
        if (!div_end) begin
          step_r <= step_r + 1'b1;
          quo_r  <= {quo_r[QW-2:0], trial_ge};
          rem_r  <= trial_ge ? CW'(trial - {1'b0, count_r}) : trial[CW-1:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_stat_r <= status_r;
      if (count_r == '0)
        out_data_r <= {{PAD_W{1'b0}}, {MW{1'b0}}, {DW{1'b1}}, {DW{1'b1}},
                       count_r, popped_r};
      else
        out_data_r <= {{PAD_W{1'b0}}, mean_val, min_r, max_r, count_r, popped_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule
